@@ rtl/chi2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi2_pkg
// Shared widths and types for the chi-square distance accumulator.
// ----------------------------------------------------------------------------
package chi2_pkg;

   localparam int ValueWidth = 16;                  // Q8.8 element
   localparam int EpsWidth   = 8;                   // Q0.8 epsilon register
   localparam int DenomWidth = ValueWidth + 2;      // a + b + eps reaches 131325
   localparam int ProdWidth  = 2 * ValueWidth;      // (a - b)^2
   localparam int FracShift  = 8;                   // term scaling by 256
   localparam int NumerWidth = ProdWidth + FracShift;
   localparam int QuotWidth  = 24;                  // term is below 2^24
   localparam int CountWidth = $clog2(QuotWidth);
   localparam int SumWidth   = 40;                  // Q24.16 running sum

   localparam logic [EpsWidth-1:0] EpsReset = EpsWidth'(1);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/chi2_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi2_div
// Restoring divider, one quotient bit per cycle over a shared subtractor.
// ----------------------------------------------------------------------------
module chi2_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [chi2_pkg::NumerWidth-1:0]   numer,
   input  logic [chi2_pkg::DenomWidth-1:0]   denom,
   output chi2_pkg::div_status_type          status,
   output logic [chi2_pkg::QuotWidth-1:0]    quotient
);
   import chi2_pkg::*;

   logic [DenomWidth-1:0] rem_ff,   rem_in;
   logic [QuotWidth-1:0]  quot_ff,  quot_in;
   logic [DenomWidth-1:0] denom_ff, denom_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff,  busy_in;
   logic [DenomWidth:0]   trial;
   logic [DenomWidth:0]   diff;

   // Trial subtract: shift in the next numerator bit, keep the difference if it fits.
   assign trial = {rem_ff, quot_ff[QuotWidth-1]};
   assign diff  = trial - {1'b0, denom_ff};

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         // The quotient fits in QuotWidth bits, so the upper numerator bits
         // already sit below the divisor and seed the remainder.
         rem_in   = DenomWidth'(numer[NumerWidth-1:QuotWidth]);
         quot_in  = numer[QuotWidth-1:0];
         denom_in = denom;
         count_in = CountWidth'(QuotWidth - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenomWidth]) begin
            rem_in  = diff[DenomWidth-1:0];
            quot_in = {quot_ff[QuotWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial[DenomWidth-1:0];
            quot_in = {quot_ff[QuotWidth-2:0], 1'b0};
         end
         count_in = count_ff - CountWidth'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
      count_ff <= count_in;
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (count_ff == '0);
   assign quotient    = quot_ff;

endmodule

@@ rtl/chi2_distance_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi2_distance_accumulator
// Chi-square histogram distance over two streamed Q8.8 vectors.
// ----------------------------------------------------------------------------
// Flow: an accepted request passes through the square, divide and accumulate
//   steps to the updated sum; on a last element rsp_valid rises with that update,
//   unless the previous result is still waiting, which holds the block in its
//   accumulate step. One pair at a time: a new one is taken only back in idle,
//   after square, the 24-step restoring divider (one quotient bit per cycle), accumulate.
// Reset: synchronous; clears the sum, the overflow flag, the response valid
//   and sets epsilon to 1.
module chi2_distance_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [chi2_pkg::ValueWidth-1:0]   req_value_a,
   input  logic [chi2_pkg::ValueWidth-1:0]   req_value_b,
   input  logic                              req_last,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [chi2_pkg::SumWidth-1:0]     rsp_distance,
   output logic                              rsp_saturated,
   // epsilon register
   input  logic                              csr_write_enable,
   input  logic [chi2_pkg::EpsWidth-1:0]     csr_write_data
);
   import chi2_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ACCUM
   } state_type;

   state_type               state_ff;
   logic [EpsWidth-1:0]     epsilon_ff;
   logic [ValueWidth-1:0]   value_a_ff;
   logic [ValueWidth-1:0]   value_b_ff;
   logic                    last_ff;
   logic                    denom_zero_ff;
   logic [SumWidth-1:0]     sum_ff;
   logic                    overflow_ff;
   logic                    rsp_valid_ff;
   logic [SumWidth-1:0]     rsp_distance_ff;
   logic                    rsp_saturated_ff;

   logic [ValueWidth-1:0]   abs_diff;
   logic [ProdWidth-1:0]    square;
   logic [NumerWidth-1:0]   numer;
   logic [DenomWidth-1:0]   denom;
   logic                    div_start;
   div_status_type          div_status;
   logic [QuotWidth-1:0]    quotient;
   logic [QuotWidth-1:0]    term;
   logic [SumWidth:0]       sum_wide;
   logic [SumWidth-1:0]     sum_in;
   logic                    overflow_in;
   logic                    out_free;
   logic                    rsp_load;

   // Epsilon register; the host writes only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EpsReset;
      end else if (csr_write_enable) begin
         epsilon_ff <= csr_write_data;
      end
   end

   // Square stage: |a - b|^2 scaled by 256, and a + b + eps. The product feeds
   // straight into the divider's load registers.
   assign abs_diff = (value_a_ff >= value_b_ff) ? (value_a_ff - value_b_ff)
                                                : (value_b_ff - value_a_ff);
   assign square   = ProdWidth'(abs_diff) * ProdWidth'(abs_diff);
   assign numer    = {square, {FracShift{1'b0}}};
   assign denom    = DenomWidth'(value_a_ff) + DenomWidth'(value_b_ff)
                   + DenomWidth'(epsilon_ff);
   assign div_start = (state_ff == ST_SQUARE);

   chi2_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (denom),
      .status   (div_status),
      .quotient (quotient)
   );

   // Accumulate: a zero denominator contributes nothing; a carry out of the
   // sum clamps it at all ones and marks the vector as saturated.
   assign term     = denom_zero_ff ? '0 : quotient;
   assign sum_wide = {1'b0, sum_ff} + (SumWidth+1)'(term);
   always_comb begin
      if (sum_wide[SumWidth]) begin
         sum_in      = '1;
         overflow_in = 1'b1;
      end else begin
         sum_in      = sum_wide[SumWidth-1:0];
         overflow_in = overflow_ff;
      end
   end

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == ST_ACCUM) && last_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load a finished vector, else drop the response once it is taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_status.done) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM: begin
               if (!last_ff) begin
                  sum_ff      <= sum_in;
                  overflow_ff <= overflow_in;
                  state_ff    <= ST_IDLE;
               end else if (out_free) begin
                  // Hand the finished vector to the output and clear for the next.
                  rsp_distance_ff  <= sum_in;
                  rsp_saturated_ff <= overflow_in;
                  sum_ff           <= '0;
                  overflow_ff      <= 1'b0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Transaction payload capture; no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         value_a_ff <= req_value_a;
         value_b_ff <= req_value_b;
         last_ff    <= req_last;
      end
      if (div_start) begin
         denom_zero_ff <= (denom == '0);
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

@@ rtl/chi2_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi2_checker
// Port-level checks for the chi-square distance accumulator.
// ----------------------------------------------------------------------------
module chi2_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [chi2_pkg::ValueWidth-1:0]   req_value_a,
   input logic [chi2_pkg::ValueWidth-1:0]   req_value_b,
   input logic                              req_last,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [chi2_pkg::SumWidth-1:0]     rsp_distance,
   input logic                              rsp_saturated,
   input logic                              csr_write_enable,
   input logic [chi2_pkg::EpsWidth-1:0]     csr_write_data
);

   // Reset leaves the block ready with no response pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_distance) && $stable(rsp_saturated)))
      else $error("stalled response changed");

   // Each transaction occupies the divider for its full run.
   a_busy_span: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##24 !req_ready)
      else $error("request accepted before divide finished");

   // A saturated result always reports the clamped maximum.
   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_distance == '1))
      else $error("saturated flag without clamped sum");

endmodule

bind chi2_distance_accumulator chi2_checker u_chi2_checker (.*);

@@ verif/chi2_distance_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi2_distance_accumulator_tb
// Streams element pairs into the chi-square distance accumulator and scores
// every returned distance and saturation flag against a cycle-free predictor
// kept in step with each accepted transaction and each epsilon write.
// ----------------------------------------------------------------------------
module chi2_distance_accumulator_tb;
   import chi2_pkg::*;

   localparam int ClockHalf       = 2;
   localparam int ResetCycles     = 7;
   localparam int SettleCycles    = 40;      // latency of a pair plus margin
   localparam int RspHoldCycles   = 600;     // long receiver hold-off
   localparam int RandomPairs     = 850;
   localparam logic [SumWidth-1:0] SumMax = '1;

   typedef struct packed {
      logic [SumWidth-1:0] distance;
      logic                saturated;
   } chi2_result_type;

   // Drive every input to a known value from time zero.
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [ValueWidth-1:0] req_value_a      = '0;
   logic [ValueWidth-1:0] req_value_b      = '0;
   logic                  req_last         = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [SumWidth-1:0]   rsp_distance;
   logic                  rsp_saturated;
   logic                  csr_write_enable = 1'b0;
   logic [EpsWidth-1:0]   csr_write_data   = '0;

   // Idle rates in percent; the receiver rate is only read by the ready process.
   int unsigned send_idle_pct = 20;
   int unsigned recv_idle_pct = 48;
   logic        rsp_hold      = 1'b0;
   event        rsp_hold_start;

   // Predictor state: epsilon copy, running sum and clamp flag.
   logic [EpsWidth-1:0] model_epsilon;
   logic [SumWidth-1:0] model_sum;
   logic                model_clamped;
   chi2_result_type     expected_distances[$];
   int unsigned         mismatch_count = 0;

   chi2_distance_accumulator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value_a      (req_value_a),
      .req_value_b      (req_value_b),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_distance     (rsp_distance),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #ClockHalf clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // One Q8.16 term: floor((a-b)^2 * 256 / (a+b+eps)), zero on a zero denominator.
   // Compute at full width so a denominator above 17 bits stays exact.
   function automatic logic [63:0] chi2_term(input logic [ValueWidth-1:0] a,
                                             input logic [ValueWidth-1:0] b,
                                             input logic [EpsWidth-1:0]   eps);
      logic [63:0] diff;
      logic [63:0] denom;
      diff  = (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
      denom = 64'(a) + 64'(b) + 64'(eps);
      if (denom == 0) return '0;
      return ((diff * diff) << FracShift) / denom;
   endfunction

   // Fold one pair into the sum; clamp at full scale and latch the flag.
   // On the closing pair queue the distance and start the next vector clean.
   function automatic void accumulate_pair(input logic [ValueWidth-1:0] a,
                                           input logic [ValueWidth-1:0] b,
                                           input logic                  is_last);
      logic [63:0] term;
      term = chi2_term(a, b, model_epsilon);
      if (term > 64'(SumMax - model_sum)) begin
         model_sum     = SumMax;
         model_clamped = 1'b1;
      end else begin
         model_sum = model_sum + term[SumWidth-1:0];
      end
      if (is_last) begin
         expected_distances.push_back('{distance: model_sum, saturated: model_clamped});
         model_sum     = '0;
         model_clamped = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: sample both channels and the epsilon port at each edge.
   // Check the response first so a result never meets its own prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      chi2_result_type want;
      if (reset) begin
         model_epsilon = EpsReset;
         model_sum     = '0;
         model_clamped = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               $error("unexpected result transaction: distance %0d", rsp_distance);
               mismatch_count++;
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
                  mismatch_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, rsp_saturated);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) model_epsilon = csr_write_data;
         if (req_valid && req_ready) accumulate_pair(req_value_a, req_value_b, req_last);
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready, forced low during a hold-off.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold off the receiver for a fixed stretch, counted here edge by edge.
   always begin
      @(rsp_hold_start);
      rsp_hold <= 1'b1;
      repeat (RspHoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sender helpers (always entered and left on a rising edge)
   // ------------------------------------------------------------------------

   // Offer one pair after a random gap; return on the edge that accepts it.
   // Leave valid high so a following pair goes out without a bubble.
   task automatic send_pair(input logic [ValueWidth-1:0] a,
                            input logic [ValueWidth-1:0] b,
                            input logic                  is_last);
      int gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value_a <= a;
      req_value_b <= b;
      req_last    <= is_last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every queued distance, then let the pipeline empty.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write epsilon only once the block has gone quiet.
   task automatic write_epsilon(input logic [EpsWidth-1:0] value);
      wait_for_drain();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mix the extremes, small values, near-top values and full-range noise.
   function automatic logic [ValueWidth-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return ValueWidth'($urandom_range(255));
         3:       return ValueWidth'($urandom_range(65535, 65280));
         default: return ValueWidth'($urandom);
      endcase
   endfunction

   // Mostly short vectors, now and then a longer one.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6) return $urandom_range(4, 1);
      if (roll < 9) return $urandom_range(16, 5);
      return $urandom_range(64, 17);
   endfunction

   // One well-formed vector: random elements, the final one marked last.
   // Now and then make b a near copy of a to get small differences.
   task automatic send_random_vector(input int length);
      logic [ValueWidth-1:0] a;
      logic [ValueWidth-1:0] b;
      for (int i = 0; i < length; i++) begin
         a = pick_value();
         b = ($urandom_range(3) == 0) ? a ^ ValueWidth'($urandom_range(15)) : pick_value();
         send_pair(a, b, i == length - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset epsilon; field extremes, alternating bit patterns, multi-pair vectors.
   task automatic test_field_extremes();
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'hFFFF, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'hFFFF, 1'b1);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);
      send_pair(16'h5555, 16'hAAAA, 1'b0);
      send_pair(16'hAAAA, 16'h5555, 1'b1);
      send_pair(16'h0100, 16'h0080, 1'b0);
      send_pair(16'h1234, 16'h1234, 1'b0);
      send_pair(16'hFFFF, 16'h0001, 1'b1);
   endtask

   // Epsilon of zero: both elements zero gives a zero denominator, term zero.
   task automatic test_zero_denominator();
      write_epsilon(8'd0);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'h0003, 16'h0001, 1'b0);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'h0001, 16'h0000, 1'b1);
   endtask

   // Largest epsilon pushes a + b + eps past 17 bits.
   task automatic test_epsilon_extremes();
      write_epsilon(8'd255);
      send_pair(16'hFFFF, 16'hFFFE, 1'b1);
      send_pair(16'hFFFF, 16'hFE00, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'hFFFF, 16'h0000, 1'b1);
      write_epsilon(8'd128);
      send_pair(16'h00FF, 16'h0001, 1'b1);
      send_pair(16'hFF00, 16'h00FF, 1'b1);
   endtask

   // Hold the receiver off while single-pair vectors keep coming, so the block
   // backs up and stalls its input; then pause until every result is back.
   task automatic test_backpressure();
      -> rsp_hold_start;
      repeat (12) send_pair(pick_value(), pick_value(), 1'b1);
      wait_for_drain();
   endtask

   // Random vectors in three idle patterns, each under a fresh epsilon.
   task automatic test_random_vectors();
      int sent;
      int length;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 48;
               write_epsilon(EpsWidth'($urandom_range(255)));
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 20;
               write_epsilon(EpsWidth'($urandom_range(3)));
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_epsilon(EpsWidth'($urandom_range(255)));
            end
         endcase
         sent = 0;
         while (sent < RandomPairs / 3) begin
            length = pick_length();
            send_random_vector(length);
            sent += length;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_zero_denominator();
      test_epsilon_extremes();
      test_backpressure();
      test_random_vectors();
      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
